### hw/rtl/lfu_pkg.sv
// Shared types, constants and request/status codes for the LFU lookup cache.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int ENTRIES_DEFAULT = 128;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 48;
    localparam int HITS_W  = 32;
    localparam int STAMP_W = 40;
    localparam int CAP_W   = 8;
    localparam int SLOT_W  = KEY_W + VALUE_W + HITS_W + STAMP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    localparam logic [1:0] REQ_LOOKUP  = 2'd0;
    localparam logic [1:0] REQ_FILL    = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_EVICTED   = 3'd3;
    localparam logic [2:0] ST_REFRESHED = 3'd4;
    localparam logic [2:0] ST_NO_MATCH  = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [HITS_W-1:0]  hits;
        logic [STAMP_W-1:0] stamp;
    } slot_t;
endpackage
`default_nettype wire

### hw/rtl/lfu_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hw/rtl/lfu_lookup_cache.sv
// LFU lookup cache: slot memory, valid bits and the scan sequencer.
//
// Usage: a request (req_type, lookup_key, fill_value) is taken at a clock edge
// where in_valid is high and in_stall is low. Exactly one result (status,
// result_value, evicted_key, entries_in_use) follows for each request; it is
// taken where out_valid is high and out_stall is low, and holds while stalled.
// Each request scans the slot memory once, one slot per cycle, comparing keys
// and tracking the eviction candidate (smallest hit count, then oldest stamp),
// then writes back at most one slot. No new request is taken while a scan
// or write-back is in progress, since the single memory port serves the
// scan and the write-back. The next request
// is taken as soon as the result register is loaded, even if it is stalled;
// a second result waits until the first is taken.
// capacity_limit is written through cfg_valid/cfg_ready while idle.
// Reset clears all valid bits at once, the stamp counter, the entry count,
// and sets the capacity to 100; slot contents need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lfu_lookup_cache
    import lfu_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CAP_W-1:0]   capacity_limit,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [KEY_W-1:0]   lookup_key,
    input  wire logic [VALUE_W-1:0] fill_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [VALUE_W-1:0]      result_value,
    output logic [KEY_W-1:0]        evicted_key,
    output logic [CAP_W-1:0]        entries_in_use
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W:0]     addr_reg;     // read address, one ahead of data
    logic [IDX_W:0]     data_idx_reg; // slot whose data is on rdata
    logic               data_v_reg;
    logic [1:0]         req_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               hit_reg, vict_v_reg, free_v_reg;
    logic [IDX_W-1:0]   hit_idx_reg, vict_idx_reg, free_idx_reg;
    slot_t              hit_slot_reg, vict_slot_reg;

    logic [2:0]         status_hold;
    logic [VALUE_W-1:0] res_hold;
    logic [KEY_W-1:0]   ev_hold;
    logic [CNT_W-1:0]   cnt_after;

    logic               we;
    logic [IDX_W-1:0]   ram_addr;
    slot_t              wslot, rslot;

    lfu_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (ram_addr),
        .wdata(wslot),
        .rdata(rslot)
    );

    // Effective capacity clamped to 1..ENTRIES.
    logic [CNT_W:0] cap_eff;
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = (CNT_W+1)'(1);
        else if (32'(cap_reg) > 32'(ENTRIES))
            cap_eff = (CNT_W+1)'(ENTRIES);
        else
            cap_eff = (CNT_W+1)'(cap_reg);
    end

    logic slot_live;
    logic [IDX_W-1:0] didx;
    assign didx      = data_idx_reg[IDX_W-1:0];
    assign slot_live = data_v_reg && valid_reg[didx];

    // Write-back decision for the done cycle.
    logic             is_fill, need_evict, do_evict, do_insert;
    logic [IDX_W-1:0] ins_idx;
    assign is_fill    = req_reg == REQ_FILL;
    assign need_evict = ({1'b0, count_reg} >= cap_eff) || !free_v_reg;
    assign do_evict   = is_fill && !hit_reg && need_evict && vict_v_reg;
    assign do_insert  = is_fill && !hit_reg && (do_evict || free_v_reg);
    assign ins_idx    = do_evict ? vict_idx_reg : free_idx_reg;

    // An eviction frees one slot and the insert takes it, so only a plain
    // insert grows the count.
    assign cnt_after = (state_reg == S_DONE && do_insert && !do_evict) ?
                       count_reg + 1'b1 : count_reg;

    logic [HITS_W-1:0] hits_inc;
    assign hits_inc = (&hit_slot_reg.hits) ? hit_slot_reg.hits
                                           : hit_slot_reg.hits + 1'b1;

    always_comb
    begin
        we       = 1'b0;
        wslot    = hit_slot_reg;
        // Idle reads park on slot 0 so the first scan cycle sees it.
        ram_addr = (state_reg == S_SCAN) ? addr_reg[IDX_W-1:0] : '0;
        if (state_reg == S_DONE)
        begin
            if (hit_reg)
            begin
                ram_addr = hit_idx_reg;
                unique case (req_reg)
                    REQ_FILL:
                    begin
                        we          = 1'b1;
                        wslot.value = val_reg;
                        wslot.hits  = hits_inc;
                    end
                    REQ_REFRESH:
                    begin
                        we          = 1'b1;
                        wslot.value = val_reg;
                    end
                    default:
                    begin
                        we         = 1'b1;
                        wslot.hits = hits_inc;
                    end
                endcase
            end
            else if (do_insert)
            begin
                we          = 1'b1;
                ram_addr    = ins_idx;
                wslot.key   = key_reg;
                wslot.value = val_reg;
                wslot.hits  = HITS_W'(1);
                wslot.stamp = stamp_reg;
            end
        end
    end

    logic [2:0]         st_next;
    logic [VALUE_W-1:0] res_next;
    logic [KEY_W-1:0]   ev_next;
    always_comb
    begin
        st_next  = ST_MISS;
        res_next = '0;
        ev_next  = '0;
        case (req_reg)
            REQ_FILL:
            begin
                if (hit_reg)
                begin
                    st_next  = ST_HIT;
                    res_next = val_reg;
                end
                else if (do_evict)
                begin
                    st_next = ST_EVICTED;
                    ev_next = vict_slot_reg.key;
                end
                else
                    st_next = ST_INSERTED;
            end
            REQ_REFRESH:
            begin
                st_next  = hit_reg ? ST_REFRESHED : ST_NO_MATCH;
                res_next = hit_reg ? val_reg : '0;
            end
            default:
            begin
                st_next  = hit_reg ? ST_HIT : ST_MISS;
                res_next = hit_reg ? hit_slot_reg.value : '0;
            end
        endcase
    end

    logic in_acc, out_acc;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_SCAN;
            S_SCAN: if (data_v_reg && data_idx_reg == (IDX_W+1)'(ENTRIES - 1))
                        state_next = S_DONE;
            S_DONE: state_next = (out_valid && out_stall) ? S_WAIT : S_IDLE;
            S_WAIT: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cap_reg    <= CAP_RESET;
            valid_reg  <= '0;
            stamp_reg  <= '0;
            count_reg  <= '0;
            out_valid  <= 1'b0;
            data_v_reg <= 1'b0;
            addr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= capacity_limit;
            if ((state_reg == S_DONE && !(out_valid && out_stall)) ||
                (state_reg == S_WAIT && !out_stall))
                out_valid <= 1'b1;
            else if (out_acc)
                out_valid <= 1'b0;
            if (in_acc)
            begin
                addr_reg   <= (IDX_W+1)'(1);
                data_v_reg <= 1'b1;
            end
            else if (state_reg == S_SCAN)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (data_idx_reg == (IDX_W+1)'(ENTRIES - 1))
                    data_v_reg <= 1'b0;
            end
            if (state_reg == S_DONE)
            begin
                if (do_insert)
                begin
                    valid_reg[ins_idx] <= 1'b1;
                    stamp_reg          <= stamp_reg + 1'b1;
                    count_reg          <= cnt_after;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg      <= req_type;
            key_reg      <= lookup_key;
            val_reg      <= fill_value;
            hit_reg      <= 1'b0;
            vict_v_reg   <= 1'b0;
            free_v_reg   <= 1'b0;
            data_idx_reg <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            data_idx_reg <= data_idx_reg + 1'b1;
            if (slot_live)
            begin
                if (!hit_reg && rslot.key == key_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= didx;
                    hit_slot_reg <= rslot;
                end
                if (!vict_v_reg || rslot.hits < vict_slot_reg.hits ||
                    (rslot.hits == vict_slot_reg.hits &&
                     rslot.stamp < vict_slot_reg.stamp))
                begin
                    vict_v_reg    <= 1'b1;
                    vict_idx_reg  <= didx;
                    vict_slot_reg <= rslot;
                end
            end
            else if (data_v_reg && !free_v_reg)
            begin
                free_v_reg   <= 1'b1;
                free_idx_reg <= didx;
            end
        end
        if (state_reg == S_DONE || (state_reg == S_WAIT && !out_stall))
        begin
            if (!(state_reg == S_DONE && out_valid && out_stall))
            begin
                status         <= state_reg == S_DONE ? st_next : status_hold;
                result_value   <= state_reg == S_DONE ? res_next : res_hold;
                evicted_key    <= state_reg == S_DONE ? ev_next : ev_hold;
                entries_in_use <= CAP_W'(cnt_after);
            end
        end
        if (state_reg == S_DONE)
        begin
            status_hold <= st_next;
            res_hold    <= res_next;
            ev_hold     <= ev_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/lfu_checker.sv
// Port-level checker for the LFU lookup cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lfu_checker
    import lfu_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic             cfg_ready,
    input wire logic [2:0]       status,
    input wire logic [KEY_W-1:0] evicted_key
);
    // A result never appears in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result too early");

    // A held result keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(status))
        else $error("stalled result changed");

    // Configuration is only accepted while requests are accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall)
        else $error("config taken while busy");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_NO_MATCH))
        else $error("bad status");

    // Only an eviction reports a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_EVICTED) |-> (evicted_key == '0))
        else $error("evicted key without eviction");
endmodule

bind lfu_lookup_cache lfu_checker u_lfu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_ready  (cfg_ready),
    .status     (status),
    .evicted_key(evicted_key)
);
`default_nettype wire
